// File: hdl/mrrc_pkg.sv
package mrrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes and reset values
    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_FUNCTION_CODE = 1'b1;
    localparam logic [7:0] RST_SLAVE_ADDRESS = 8'h01;
    localparam logic [7:0] RST_FUNCTION_CODE = 8'h03;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_EXCEPT = 2'd2;
    localparam logic [1:0] ST_LENGTH = 2'd3;

    // one finished frame, handed from the byte front end to the result back end
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] exc;
        logic [8:0] flen;
        logic [5:0] nw;
        logic       bank;
    } t_frame_desc;

endpackage

// File: hdl/mrrc_ram.sv
module mrrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mrrc_front.sv
module mrrc_front #(
    parameter int MAX_FRAME = 256,
    parameter int MAX_WORDS = 32,
    localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_end,
    input  logic [7:0]            i_slave_address,
    input  logic [7:0]            i_function_code,
    input  logic                  i_hold,
    input  logic                  i_q_full,
    output logic                  o_push,
    output mrrc_pkg::t_frame_desc o_desc,
    output logic                  o_wr_en,
    output logic [IW:0]           o_wr_addr,
    output logic [15:0]           o_wr_data
);

    localparam int CW = $clog2(MAX_FRAME + 2);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_FRAME + 1);
    localparam logic [CW-1:0] CNT_FRAME = CW'(MAX_FRAME);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic [1:0]    r_state;
    logic [15:0]   r_crc;
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_bit;
    logic          r_end;
    logic          r_bank;
    logic [7:0]    r_dly0;
    logic [7:0]    r_dly1;
    logic [7:0]    r_addr;
    logic [7:0]    r_func;
    logic [7:0]    r_count;
    logic [7:0]    r_high;

    logic          accept;
    logic [15:0]   pos16;
    logic [15:0]   wi16;
    logic [15:0]   flen16;
    logic [15:0]   nw16;
    logic [15:0]   lim16;
    logic          foreign;
    logic          too;
    logic          crc_bad;
    logic [15:0]   crc_step;

    assign o_stall = (r_state != S_IDLE) || i_hold;
    assign accept  = i_valid && !o_stall;

    assign crc_step = r_crc[0] ? ((r_crc >> 1) ^ mrrc_pkg::CRC_POLY) : (r_crc >> 1);

    // word store write: second byte of each register pair
    assign pos16     = {{(16-CW){1'b0}}, r_cnt};
    assign wi16      = (pos16 - 16'd4) >> 1;
    assign o_wr_en   = accept && (pos16 >= 16'd4) && (r_cnt <= CNT_FRAME) && !r_cnt[0]
                       && (wi16 < 16'(MAX_WORDS));
    assign o_wr_addr = {r_bank, wi16[IW-1:0]};
    assign o_wr_data = {r_high, i_rx_byte};

    // frame end checks
    assign flen16  = (pos16 >= 16'd2) ? (pos16 - 16'd2) : 16'd0;
    assign foreign = (r_addr != i_slave_address);
    assign too     = (pos16 > 16'(MAX_FRAME)) || (pos16 < 16'd5);
    assign crc_bad = (r_crc != {r_dly1, r_dly0});
    assign lim16   = (flen16 - 16'd3) >> 1;

    always_comb begin
        nw16 = {9'd0, r_count[7:1]};
        if (lim16 < nw16) begin
            nw16 = lim16;
        end
        if (16'(MAX_WORDS) < nw16) begin
            nw16 = 16'(MAX_WORDS);
        end
        if (16'd32 < nw16) begin
            nw16 = 16'd32;
        end

        o_desc.flen = flen16[8:0];
        o_desc.bank = r_bank;
        o_desc.exc  = 8'd0;
        o_desc.nw   = 6'd0;
        if (too) begin
            o_desc.status = mrrc_pkg::ST_LENGTH;
        end else if (crc_bad) begin
            o_desc.status = mrrc_pkg::ST_CRC;
        end else if (r_func != i_function_code) begin
            o_desc.status = mrrc_pkg::ST_EXCEPT;
            o_desc.exc    = r_count;
        end else begin
            o_desc.status = mrrc_pkg::ST_OK;
            o_desc.nw     = nw16[5:0];
        end
    end

    assign o_push = (r_state == S_FIN) && !foreign && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_crc   <= mrrc_pkg::CRC_INIT;
            r_cnt   <= '0;
            r_bit   <= 3'd0;
            r_end   <= 1'b0;
            r_bank  <= 1'b0;
            r_dly0  <= 8'd0;
            r_dly1  <= 8'd0;
            r_addr  <= 8'd0;
            r_func  <= 8'd0;
            r_count <= 8'd0;
            r_high  <= 8'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_end  <= i_frame_end;
                        r_dly0 <= r_dly1;
                        r_dly1 <= i_rx_byte;
                        if (r_cnt == CW'(0)) begin
                            r_addr <= i_rx_byte;
                        end else if (r_cnt == CW'(1)) begin
                            r_func <= i_rx_byte;
                        end else if (r_cnt == CW'(2)) begin
                            r_count <= i_rx_byte;
                        end else if (r_cnt <= CNT_FRAME && r_cnt[0]) begin
                            r_high <= i_rx_byte;
                        end
                        if (r_cnt < CNT_MAX) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (r_cnt >= CW'(2)) begin
                            r_crc   <= r_crc ^ {8'h00, r_dly0};
                            r_bit   <= 3'd0;
                            r_state <= S_SHIFT;
                        end else if (i_frame_end) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SHIFT: begin
                    r_crc <= crc_step;
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= r_end ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    if (foreign || !i_q_full) begin
                        if (!foreign) begin
                            r_bank <= !r_bank;
                        end
                        r_state <= S_IDLE;
                        r_crc   <= mrrc_pkg::CRC_INIT;
                        r_cnt   <= '0;
                        r_end   <= 1'b0;
                        r_dly0  <= 8'd0;
                        r_dly1  <= 8'd0;
                        r_addr  <= 8'd0;
                        r_func  <= 8'd0;
                        r_count <= 8'd0;
                        r_high  <= 8'd0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("byte counter past saturation");

    a_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !i_hold)
        else $error("word written while both banks are in use");

endmodule

// File: hdl/mrrc_queue.sv
module mrrc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mrrc_pkg::t_frame_desc i_desc,
    input  logic                  i_pop,
    output mrrc_pkg::t_frame_desc o_head,
    output logic                  o_empty,
    output logic                  o_full,
    output logic [1:0]            o_count
);

    mrrc_pkg::t_frame_desc r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("frame queue underflow");

endmodule

// File: hdl/mrrc_back.sv
module mrrc_back #(
    parameter int MAX_WORDS = 32,
    localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrrc_pkg::t_frame_desc i_desc,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [IW:0]           o_rd_addr,
    input  logic [15:0]           i_rd_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_result_kind,
    output logic [15:0]           o_reg_word,
    output logic [4:0]            o_word_index,
    output logic [1:0]            o_frame_status,
    output logic [7:0]            o_exception_code,
    output logic [8:0]            o_frame_length,
    output logic                  o_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_NEXT = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;

    logic [1:0]            r_state;
    mrrc_pkg::t_frame_desc r_desc;
    logic [5:0]            r_idx;
    logic                  r_ovalid;
    logic                  r_kind;
    logic [15:0]           r_word;
    logic [4:0]            r_windex;
    logic [1:0]            r_status;
    logic [7:0]            r_exc;
    logic [8:0]            r_flen;
    logic                  r_last;

    logic out_free;
    logic more;
    logic load_word;
    logic load_status;

    assign out_free    = !r_ovalid || !i_stall;
    assign more        = (r_idx < r_desc.nw);
    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_busy      = (r_state != B_IDLE);
    assign o_rd_en     = (r_state == B_NEXT) && more;
    assign o_rd_addr   = {r_desc.bank, r_idx[IW-1:0]};
    assign load_word   = (r_state == B_LOAD) && out_free;
    assign load_status = (r_state == B_NEXT) && !more && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_idx    <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_word || load_status) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_idx   <= 6'd0;
                        r_state <= B_NEXT;
                    end
                end
                B_NEXT: begin
                    if (more) begin
                        r_state <= B_LOAD;
                    end else if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                B_LOAD: begin
                    if (out_free) begin
                        r_idx   <= r_idx + 6'd1;
                        r_state <= B_NEXT;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // descriptor and result word, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (load_word) begin
            r_kind   <= mrrc_pkg::KIND_WORD;
            r_word   <= i_rd_data;
            r_windex <= r_idx[4:0];
            r_status <= mrrc_pkg::ST_OK;
            r_exc    <= 8'd0;
            r_flen   <= r_desc.flen;
            r_last   <= 1'b0;
        end else if (load_status) begin
            r_kind   <= mrrc_pkg::KIND_STATUS;
            r_word   <= 16'd0;
            r_windex <= 5'd0;
            r_status <= r_desc.status;
            r_exc    <= r_desc.exc;
            r_flen   <= r_desc.flen;
            r_last   <= 1'b1;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_result_kind    = r_kind;
    assign o_reg_word       = r_word;
    assign o_word_index     = r_windex;
    assign o_frame_status   = r_status;
    assign o_exception_code = r_exc;
    assign o_frame_length   = r_flen;
    assign o_last           = r_last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> (r_idx <= r_desc.nw))
        else $error("word index ran past frame word count");

endmodule

// File: hdl/modbus_rtu_response_checker_unit.sv
// Modbus RTU response checker.
// Input channel (i_valid / o_stall): one frame byte per word, i_frame_end high
// on the last byte. Output channel (o_valid / i_stall): for a good frame, one
// word per register value (o_result_kind 0), then one status word
// (o_result_kind 1, o_last 1). Bad frames give only the status word; frames
// addressed to another slave give nothing.
// The byte front end takes the first two bytes of a frame directly and runs
// the CRC shift state after every later byte (CRC shifted one bit per cycle),
// then a finish state after the closing byte; the result back end takes a frame,
// then for each register word reads the word store and loads the output, then
// loads the status word. Two banks of word store let the next frame stream in
// while the previous one is still being emitted; input is stalled while two
// frames are outstanding.
// Configuration: i_cfg_we writes slave address (index 0) or function code
// (index 1); write only while the block is idle.
// Reset (synchronous, active low): slave address 1, function code 3, frame
// state and queue cleared. A stalled result word holds on the output register.
module modbus_rtu_response_checker_unit #(
    parameter int MAX_FRAME = 256,
    parameter int MAX_WORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [15:0] o_reg_word,
    output logic [4:0]  o_word_index,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_exception_code,
    output logic [8:0]  o_frame_length,
    output logic        o_last
);

    localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [7:0] r_slave_address;
    logic [7:0] r_function_code;

    logic                  push;
    logic                  pop;
    logic                  q_empty;
    logic                  q_full;
    logic [1:0]            q_count;
    logic                  back_busy;
    logic                  hold;
    mrrc_pkg::t_frame_desc push_desc;
    mrrc_pkg::t_frame_desc head_desc;
    logic                  wr_en;
    logic [IW:0]           wr_addr;
    logic [15:0]           wr_data;
    logic                  rd_en;
    logic [IW:0]           rd_addr;
    logic [15:0]           rd_data;
    logic [2:0]            outstanding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= mrrc_pkg::RST_SLAVE_ADDRESS;
            r_function_code <= mrrc_pkg::RST_FUNCTION_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrrc_pkg::CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg_data;
                mrrc_pkg::CFG_FUNCTION_CODE: r_function_code <= i_cfg_data;
                default: begin
                    r_slave_address <= r_slave_address;
                end
            endcase
        end
    end

    // frames holding a word bank: queued plus the one being emitted
    assign outstanding = {1'b0, q_count} + {2'b00, back_busy};
    assign hold        = (outstanding >= 3'd2);

    mrrc_front #(
        .MAX_FRAME (MAX_FRAME),
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_end     (i_frame_end),
        .i_slave_address (r_slave_address),
        .i_function_code (r_function_code),
        .i_hold          (hold),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_desc          (push_desc),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data)
    );

    mrrc_ram #(
        .WIDTH (16),
        .DEPTH (2 << IW)
    ) u_word_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    mrrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head_desc),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    mrrc_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_desc           (head_desc),
        .i_empty          (q_empty),
        .o_pop            (pop),
        .o_busy           (back_busy),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_reg_word       (o_reg_word),
        .o_word_index     (o_word_index),
        .o_frame_status   (o_frame_status),
        .o_exception_code (o_exception_code),
        .o_frame_length   (o_frame_length),
        .o_last           (o_last)
    );

    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outstanding <= 3'd2)
        else $error("more than two frames hold word banks");

endmodule

// File: tb/sv/modbus_rtu_response_checker_unit_tb.sv
module modbus_rtu_response_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME    = 256;
    localparam int MAX_WORDS    = 32;
    localparam int SETTLE_TICKS = 120;

    typedef struct packed {
        logic [7:0] b;
        logic       fend;
    } t_rx_item;

    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic [4:0]  idx;
        logic [1:0]  status;
        logic [7:0]  exc;
        logic [8:0]  flen;
        logic        last;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_reg_word;
    logic [4:0]  o_word_index;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_exception_code;
    logic [8:0]  o_frame_length;
    logic        o_last;

    modbus_rtu_response_checker_unit #(
        .MAX_FRAME(MAX_FRAME),
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_rx_byte(i_rx_byte),
        .i_frame_end(i_frame_end),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result_kind(o_result_kind),
        .o_reg_word(o_reg_word),
        .o_word_index(o_word_index),
        .o_frame_status(o_frame_status),
        .o_exception_code(o_exception_code),
        .o_frame_length(o_frame_length),
        .o_last(o_last)
    );

    t_rx_item      pending_bytes[$];
    t_frame_result expected_results[$];
    logic [7:0]    frame_buf[$];
    int            err_count = 0;
    int            queued_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // shadow of the block: config and per-frame state
    logic [7:0]  cfg_slave = mrrc_pkg::RST_SLAVE_ADDRESS;
    logic [7:0]  cfg_func = mrrc_pkg::RST_FUNCTION_CODE;
    logic [15:0] crc_run;
    logic [8:0]  rx_count;
    logic [7:0]  lag0, lag1;
    logic [7:0]  hdr_addr, hdr_func, hdr_count, pend_high;
    logic [15:0] reg_buf[MAX_WORDS];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("[modbus_rtu_response_checker_unit] ERROR");
        $finish;
    end

    function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ mrrc_pkg::CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        crc_run   = mrrc_pkg::CRC_INIT;
        rx_count  = '0;
        lag0      = '0;
        lag1      = '0;
        hdr_addr  = '0;
        hdr_func  = '0;
        hdr_count = '0;
        pend_high = '0;
    endtask

    // updates the shadow with one accepted byte, queues the results it causes
    task automatic predict_byte(logic [7:0] b, logic fend);
        int            pos, total, flen, nw, lim, wi;
        logic [1:0]    st;
        logic [7:0]    exc;
        t_frame_result r;
        pos = rx_count;
        if (pos >= 2) crc_run = crc_step(crc_run, lag0);
        lag0 = lag1;
        lag1 = b;
        if (pos == 0) hdr_addr = b;
        else if (pos == 1) hdr_func = b;
        else if (pos == 2) hdr_count = b;
        else if (pos <= MAX_FRAME) begin
            if (((pos - 3) & 1) == 0) begin
                pend_high = b;
            end else begin
                wi = (pos - 4) >> 1;
                if (wi < MAX_WORDS) reg_buf[wi] = {pend_high, b};
            end
        end
        if (rx_count < MAX_FRAME + 1) rx_count = rx_count + 9'd1;

        if (fend) begin
            total = rx_count;
            flen  = (total >= 2) ? total - 2 : 0;
            if (hdr_addr == cfg_slave) begin
                exc = '0;
                nw  = 0;
                if (total > MAX_FRAME || total < 5) begin
                    st = mrrc_pkg::ST_LENGTH;
                end else if (crc_run[7:0] != lag0 || crc_run[15:8] != lag1) begin
                    st = mrrc_pkg::ST_CRC;
                end else if (hdr_func != cfg_func) begin
                    st  = mrrc_pkg::ST_EXCEPT;
                    exc = hdr_count;
                end else begin
                    st  = mrrc_pkg::ST_OK;
                    nw  = hdr_count >> 1;
                    lim = (flen - 3) >> 1;
                    if (lim < nw) nw = lim;
                    if (MAX_WORDS < nw) nw = MAX_WORDS;
                    if (nw > 32) nw = 32;
                end
                for (int i = 0; i < nw; i++) begin
                    r.kind   = mrrc_pkg::KIND_WORD;
                    r.word   = reg_buf[i];
                    r.idx    = i[4:0];
                    r.status = mrrc_pkg::ST_OK;
                    r.exc    = '0;
                    r.flen   = flen[8:0];
                    r.last   = 1'b0;
                    expected_results.push_back(r);
                end
                r.kind   = mrrc_pkg::KIND_STATUS;
                r.word   = '0;
                r.idx    = '0;
                r.status = st;
                r.exc    = exc;
                r.flen   = flen[8:0];
                r.last   = 1'b1;
                expected_results.push_back(r);
            end
            clear_frame_state();
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result();
        t_frame_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual kind %0d status %0d",
                     $time, o_result_kind, o_frame_status);
            err_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("result_kind", want.kind, o_result_kind);
            check_field("reg_word", want.word, o_reg_word);
            check_field("word_index", want.idx, o_word_index);
            check_field("frame_status", want.status, o_frame_status);
            check_field("exception_code", want.exc, o_exception_code);
            check_field("frame_length", want.flen, o_frame_length);
            check_field("last", want.last, o_last);
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_byte(i_rx_byte, i_frame_end);
                void'(pending_bytes.pop_front());
            end
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid     <= 1'b1;
                i_rx_byte   <= pending_bytes[0].b;
                i_frame_end <= pending_bytes[0].fend;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result();
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // moves frame_buf to the byte queue, optionally with a trailing CRC
    task automatic queue_frame(bit add_crc, bit bad_crc);
        logic [15:0] c;
        t_rx_item    it;
        c = mrrc_pkg::CRC_INIT;
        foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
        if (add_crc) begin
            if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
        end
        foreach (frame_buf[i]) begin
            it.b    = frame_buf[i];
            it.fend = (i == frame_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        queued_count += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic add_random_bytes(int n);
        for (int i = 0; i < n; i++) frame_buf.push_back($urandom_range(255));
    endtask

    task automatic gen_random_frame();
        int         sel, n;
        logic [7:0] tmp;
        sel = $urandom_range(99);
        frame_buf.delete();
        if (sel < 55) begin
            // well-formed register response, a few with odd byte counts or bad CRC
            n = $urandom_range(5);
            frame_buf.push_back(cfg_slave);
            frame_buf.push_back(cfg_func);
            if (sel < 40) frame_buf.push_back(2 * n);
            else          frame_buf.push_back($urandom_range(255));
            add_random_bytes(2 * n + ((sel >= 40 && sel < 44) ? 1 : 0));
            queue_frame(1, sel >= 47);
        end else if (sel < 67) begin
            tmp = $urandom_range(255, 1);
            frame_buf.push_back(cfg_slave);
            frame_buf.push_back(($urandom_range(1) == 1) ? (cfg_func | 8'h80) : (cfg_func ^ tmp));
            add_random_bytes(1 + (($urandom_range(3) == 0) ? $urandom_range(3) : 0));
            queue_frame(1, 0);
        end else if (sel < 77) begin
            tmp = $urandom_range(255, 1);
            frame_buf.push_back(cfg_slave ^ tmp);
            frame_buf.push_back(cfg_func);
            add_random_bytes($urandom_range(6));
            queue_frame(1, $urandom_range(1));
        end else if (sel < 88) begin
            // too short, with or without something like a CRC
            frame_buf.push_back(cfg_slave);
            add_random_bytes($urandom_range(3));
            queue_frame(0, 0);
        end else begin
            n = $urandom_range(10, 1);
            add_random_bytes(n);
            if ($urandom_range(1) == 1) frame_buf[0] = cfg_slave;
            queue_frame(0, 0);
        end
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mrrc_pkg::CFG_SLAVE_ADDRESS) cfg_slave = data;
        else                                    cfg_func  = data;
    endtask

    initial begin
        logic [7:0] new_slave, new_func;
        clear_frame_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 20; recv_idle_pct = 73; end
                1: begin send_idle_pct = 73; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                1: begin new_slave = 8'h00; new_func = 8'h00; end
                2: begin new_slave = 8'hFF; new_func = 8'hFF; end
                3: begin new_slave = 8'h5A; new_func = 8'h04; end
                default: begin
                    new_slave = mrrc_pkg::RST_SLAVE_ADDRESS;
                    new_func  = mrrc_pkg::RST_FUNCTION_CODE;
                end
            endcase
            if (ph > 0) begin
                cfg_write(mrrc_pkg::CFG_SLAVE_ADDRESS, new_slave);
                cfg_write(mrrc_pkg::CFG_FUNCTION_CODE, new_func);
                @(negedge i_clk);
            end

            if (ph == 0) begin
                // good frame with extreme words
                frame_buf = '{8'h01, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
                queue_frame(1, 0);
                // exception response
                frame_buf = '{8'h01, 8'h83, 8'h02};
                queue_frame(1, 0);
                // bad CRC
                frame_buf = '{8'h01, 8'h03, 8'h02, 8'h12, 8'h34};
                queue_frame(1, 1);
                // another slave
                frame_buf = '{8'hFF, 8'h03, 8'h00};
                queue_frame(1, 0);
                // single byte frame
                frame_buf = '{8'h01};
                queue_frame(0, 0);
                // sender holds off until every status word is back
                settle();

                // full word buffer, words past the buffer dropped
                frame_buf = '{8'h01, 8'h03, 8'hFF};
                add_random_bytes(70);
                queue_frame(1, 0);
                // overlong frame
                frame_buf = '{8'h01, 8'h03, 8'hFF};
                add_random_bytes(MAX_FRAME);
                queue_frame(1, 0);
            end

            queued_count = 0;
            while (queued_count < 15) gen_random_frame();
            settle();
        end

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("[modbus_rtu_response_checker_unit] OK");
        end else begin
            $display("[modbus_rtu_response_checker_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mrrc_pkg.sv
hdl/mrrc_ram.sv
hdl/mrrc_front.sv
hdl/mrrc_queue.sv
hdl/mrrc_back.sv
hdl/modbus_rtu_response_checker_unit.sv
tb/sv/modbus_rtu_response_checker_unit_tb.sv
